>>> hw/rtl/sacl_pkg.sv
// Shared types and constants for the set-associative cache tag lookup.
// Holds the controller state enum and the command/status structs.
// No dependencies.
package sacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int WAY_OUT_W = 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic scan_init;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_scan;
        logic scan_last;
        logic out_busy;
    } t_sts;

endpackage

>>> hw/rtl/sacl_ctrl.sv
// Controller state machine for the cache tag lookup.
// Sequences the clearing pass, lookup, LRU victim scan and write-back.
// Depends on sacl_pkg.
module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (i_sts.need_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end else if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.scan_last) |=> (r_state == ST_DONE))
        else $error("scan end did not move to write-back");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_sts.out_busy)
        else $error("write-back while output word still held");

endmodule

>>> hw/rtl/sacl_dp.sv
// Datapath for the cache tag lookup: set memories, tag compare, victim
// choice, LRU scan registers, totals and the output word register.
// Depends on sacl_pkg.
module sacl_dp
    import sacl_pkg::*;
#(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_out_stall,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic                  o_hit,
    output logic [WAY_OUT_W-1:0]  o_way,
    output logic [CNT_W-1:0]      o_hit_count,
    output logic [CNT_W-1:0]      o_miss_count
);

    localparam int OFS_W = $clog2(BLOCK_BYTES);
    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = $clog2(WAYS);
    localparam int TAG_W = ADDR_W - OFS_W - SET_W;

    logic [WAYS-1:0]              mem_valid [SETS];
    logic [WAYS-1:0][TAG_W-1:0]   mem_tag   [SETS];
    logic [WAYS-1:0][STAMP_W-1:0] mem_stamp [SETS];
    logic [WAY_W-1:0]             mem_rr    [SETS];

    logic [WAYS-1:0]              r_row_valid;
    logic [WAYS-1:0][TAG_W-1:0]   r_row_tag;
    logic [WAYS-1:0][STAMP_W-1:0] r_row_stamp;
    logic [WAY_W-1:0]             r_row_rr;

    logic                 r_mode;
    logic [SET_W-1:0]     r_clr;
    logic [SET_W-1:0]     r_set;
    logic [TAG_W-1:0]     r_tag;
    logic [STAMP_W-1:0]   r_access;
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_misses;
    logic [WAY_W-1:0]     r_scan_idx;
    logic [WAY_W-1:0]     r_best_way;
    logic [STAMP_W-1:0]   r_best_stamp;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [WAY_OUT_W-1:0] r_out_way;

    logic [SET_W-1:0]             in_set;
    logic [TAG_W-1:0]             in_tag;
    logic [SET_W-1:0]             rd_set;
    logic                         hit;
    logic [WAY_W-1:0]             hit_way;
    logic                         inv_found;
    logic [WAY_W-1:0]             inv_way;
    logic                         full;
    logic [WAY_W-1:0]             chosen;
    logic [WAYS-1:0]              n_valid;
    logic [WAYS-1:0][TAG_W-1:0]   n_tag;
    logic [WAYS-1:0][STAMP_W-1:0] n_stamp;
    logic [WAY_W-1:0]             n_rr;
    logic [STAMP_W-1:0]           n_access;
    logic [CNT_W-1:0]             n_hits;
    logic [CNT_W-1:0]             n_misses;

    assign in_set = i_address[OFS_W +: SET_W];
    assign in_tag = i_address[ADDR_W-1 -: TAG_W];
    assign rd_set = i_cmd.accept ? in_set : r_set;

    // hold the set row of the current word
    always_ff @(posedge i_clk) begin
        r_row_valid <= mem_valid[rd_set];
        r_row_tag   <= mem_tag[rd_set];
        r_row_stamp <= mem_stamp[rd_set];
        r_row_rr    <= mem_rr[rd_set];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_valid[r_clr] <= '0;
            mem_rr[r_clr]    <= '0;
        end else if (i_cmd.finish) begin
            mem_valid[r_set] <= n_valid;
            mem_rr[r_set]    <= n_rr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            mem_tag[r_set]   <= n_tag;
            mem_stamp[r_set] <= n_stamp;
        end
    end

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_row_valid[w] && r_row_tag[w] == r_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!r_row_valid[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
    end

    assign full = &r_row_valid;

    always_comb begin
        if (hit) begin
            chosen = hit_way;
        end else if (inv_found) begin
            chosen = inv_way;
        end else if (r_mode) begin
            chosen = r_row_rr;
        end else begin
            chosen = r_best_way;
        end
    end

    assign n_access = r_access + 1'b1;

    always_comb begin
        n_valid         = r_row_valid;
        n_tag           = r_row_tag;
        n_stamp         = r_row_stamp;
        n_valid[chosen] = 1'b1;
        n_tag[chosen]   = r_tag;
        n_stamp[chosen] = n_access;
    end

    always_comb begin
        n_rr = r_row_rr;
        if (!hit && full && r_mode) begin
            n_rr = (r_row_rr == WAY_W'(WAYS - 1)) ? '0 : WAY_W'(r_row_rr + 1'b1);
        end
    end

    assign n_hits   = (hit && r_hits != '1) ? r_hits + 1'b1 : r_hits;
    assign n_misses = (!hit && r_misses != '1) ? r_misses + 1'b1 : r_misses;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set <= in_set;
            r_tag <= in_tag;
        end
    end

    // advance the oldest-stamp search one way per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_idx   <= WAY_W'(1);
            r_best_way   <= '0;
            r_best_stamp <= r_row_stamp[0];
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= WAY_W'(r_scan_idx + 1'b1);
            if (r_row_stamp[r_scan_idx] < r_best_stamp) begin
                r_best_way   <= r_scan_idx;
                r_best_stamp <= r_row_stamp[r_scan_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_clr       <= '0;
            r_access    <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr <= SET_W'(r_clr + 1'b1);
            end
            if (i_cmd.finish) begin
                r_access    <= n_access;
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_hit    <= hit;
            r_out_way    <= WAY_OUT_W'(chosen);
            o_hit_count  <= n_hits;
            o_miss_count <= n_misses;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_way       = r_out_way;

    assign o_sts.clr_last  = (r_clr == SET_W'(SETS - 1));
    assign o_sts.need_scan = !hit && full && !r_mode;
    assign o_sts.scan_last = (r_scan_idx == WAY_W'(WAYS - 1));
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> (r_scan_idx != '0))
        else $error("scan step on way zero");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("output word not loaded after write-back");

endmodule

>>> hw/rtl/set_assoc_cache_tag_lookup_core.sv
// Set-associative tag lookup top level: joins sacl_ctrl and sacl_dp, uses sacl_pkg.
// Accept registers the set row; in the lookup state a hit, fill or round-robin word is
// written back and loads the output register, while an LRU replacement of a full set
// first runs the one-way-per-cycle victim scan. A new word is taken only once the last
// one is written back; a held output word stalls the write-back. After reset a clearing
// pass clears valid bits and pointers, stalling input; configuration writes are taken.
module set_assoc_cache_tag_lookup_core
    import sacl_pkg::*;
#(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [WAY_OUT_W-1:0]  o_way,
    output logic [CNT_W-1:0]      o_hit_count,
    output logic [CNT_W-1:0]      o_miss_count
);

    t_cmd cmd;
    t_sts sts;

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sacl_dp #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_address    (i_address),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_stall  (i_out_stall),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_hit_count  (o_hit_count),
        .o_miss_count (o_miss_count)
    );

endmodule

>>> sim/tb.sv
// Testbench for set_assoc_cache_tag_lookup_core: drives address words, predicts hit/way
// and the hit/miss totals in both replacement modes, and checks every result word.
// Depends on sacl_pkg and the core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sacl_pkg::*;

    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 16;
    localparam int OFS_W       = $clog2(BLOCK_BYTES);
    localparam int IDX_W       = $clog2(SETS);
    localparam int TAG_W       = ADDR_W - OFS_W - IDX_W;

    localparam logic MODE_LRU = 1'b0;
    localparam logic MODE_RR  = 1'b1;

    typedef struct {
        logic [ADDR_W-1:0]    addr;
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
    } t_lookup;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [ADDR_W-1:0]    i_address    = '0;
    logic                 i_cfg_we     = 1'b0;
    logic                 i_cfg_wdata  = 1'b0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_hit;
    logic [WAY_OUT_W-1:0] o_way;
    logic [CNT_W-1:0]     o_hit_count;
    logic [CNT_W-1:0]     o_miss_count;

    // predicted cache state
    bit [TAG_W-1:0]   line_tag   [SETS][WAYS];
    bit               line_valid [SETS][WAYS];
    bit [31:0]        line_stamp [SETS][WAYS];
    int unsigned      rr_next    [SETS];
    bit [31:0]        access_ctr = '0;
    bit [CNT_W-1:0]   hit_total  = '0;
    bit [CNT_W-1:0]   miss_total = '0;
    logic             repl_mode  = MODE_LRU;

    t_lookup pending_lookups[$];
    int      mismatches = 0;
    int      burst_left = 0;
    bit      eager      = 1'b0;
    int      stall_left = 0;
    int      stall_kind = 0;

    set_assoc_cache_tag_lookup_core #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_address    (i_address),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_hit_count  (o_hit_count),
        .o_miss_count (o_miss_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_lookup predict_lookup(input logic [ADDR_W-1:0] a);
        t_lookup        r;
        bit [TAG_W-1:0] tag;
        int             set;
        int             w;
        int             pick;
        bit             found;
        tag = a[ADDR_W-1 -: TAG_W];
        set = a[OFS_W +: IDX_W];
        access_ctr = access_ctr + 1;
        found = 1'b0;
        pick = 0;
        for (w = 0; w < WAYS; w++) begin
            if (!found && line_valid[set][w] && line_tag[set][w] == tag) begin
                found = 1'b1;
                pick = w;
            end
        end
        if (found) begin
            if (hit_total != '1) hit_total = hit_total + 1;
            line_stamp[set][pick] = access_ctr;
        end else begin
            if (miss_total != '1) miss_total = miss_total + 1;
            pick = -1;
            for (w = 0; w < WAYS; w++) begin
                if (pick < 0 && !line_valid[set][w]) pick = w;
            end
            if (pick < 0) begin
                if (repl_mode == MODE_LRU) begin
                    pick = 0;
                    for (w = 1; w < WAYS; w++) begin
                        if (line_stamp[set][w] < line_stamp[set][pick]) pick = w;
                    end
                end else begin
                    pick = rr_next[set];
                    rr_next[set] = (pick + 1) % WAYS;
                end
            end
            line_valid[set][pick] = 1'b1;
            line_tag[set][pick]   = tag;
            line_stamp[set][pick] = access_ctr;
        end
        r.addr   = a;
        r.hit    = found;
        r.way    = WAY_OUT_W'(pick);
        r.hits   = hit_total;
        r.misses = miss_total;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                    input int set, input int ofs);
        return {tag, IDX_W'(set), OFS_W'(ofs)};
    endfunction

    task automatic send_word(input logic [ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = eager ? 0 : $urandom_range(0, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_address  <= a;
        do @(posedge i_clk); while (o_in_stall);
        pending_lookups.push_back(predict_lookup(a));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (WAYS + 2) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        repl_mode = m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_lookup();
        send_word(32'h0000_0000);
        send_word(32'h0000_000F);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFF0);
        send_word(line_addr('0, SETS - 1, 0));
    endtask

    task automatic test_lru_victim();
        send_word(line_addr(22'h3F_FFFF, 1, 0));
        send_word(line_addr(22'h00_0001, 1, 3));
        send_word(line_addr(22'h2A_AAAA, 1, 7));
        send_word(line_addr(22'h15_5555, 1, 15));
        send_word(line_addr(22'h00_0001, 1, 1));
        send_word(line_addr(22'h00_0005, 1, 2));
        send_word(line_addr(22'h00_0006, 1, 4));
        send_word(line_addr(22'h15_5555, 1, 9));
        send_word(line_addr(22'h00_0007, 1, 0));
    endtask

    task automatic test_round_robin();
        set_mode(MODE_RR);
        // pointer of a set replaced only by LRU so far still names way 0
        send_word(line_addr(22'h00_0008, 1, 0));
        send_word(line_addr(22'h12_3456, 2, 0));
        send_word(line_addr(22'h23_4567, 2, 0));
        send_word(line_addr(22'h34_5678, 2, 0));
        send_word(line_addr(22'h05_6789, 2, 0));
        send_word(line_addr(22'h23_4567, 2, 5));
        send_word(line_addr(22'h00_0010, 2, 0));
        send_word(line_addr(22'h00_0011, 2, 0));
        send_word(line_addr(22'h00_0012, 2, 0));
        send_word(line_addr(22'h00_0013, 2, 0));
        send_word(line_addr(22'h00_0014, 2, 0));
    endtask

    task automatic test_random_traffic();
        logic [TAG_W-1:0]  tags [8];
        int                sets [4];
        int                n_tags;
        int                n_sets;
        int                k;
        int                phase;
        logic [ADDR_W-1:0] a;
        for (phase = 0; phase < 7; phase++) begin
            set_mode((phase % 2 == 0) ? MODE_LRU : MODE_RR);
            eager  = ($urandom_range(0, 3) == 0);
            n_tags = $urandom_range(5, 8);
            n_sets = $urandom_range(1, 4);
            for (k = 0; k < 8; k++) tags[k] = TAG_W'($urandom);
            for (k = 0; k < 4; k++) sets[k] = $urandom_range(0, SETS - 1);
            if (phase == 1) begin
                tags[0] = '1;
                tags[1] = '0;
                sets[0] = SETS - 1;
            end
            repeat (200) begin
                if ($urandom_range(0, 6) == 0) begin
                    a = $urandom;
                end else begin
                    a = line_addr(tags[$urandom_range(0, n_tags - 1)],
                                  sets[$urandom_range(0, n_sets - 1)],
                                  $urandom_range(0, BLOCK_BYTES - 1));
                end
                send_word(a);
                if ($urandom_range(0, 150) == 0) drain_results();
            end
        end
    endtask

    // receiver stall pattern: free-running, bursty or mostly-stalled stretches
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_kind)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                i_out_stall <= ($urandom_range(0, 5) != 0);
            end
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_lookup want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lookups.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word: hit %0b way %0d hits %0d misses %0d",
                             o_hit, o_way, o_hit_count, o_miss_count);
                mismatches++;
            end else begin
                want = pending_lookups.pop_front();
                if (o_hit !== want.hit || o_way !== want.way ||
                    o_hit_count !== want.hits || o_miss_count !== want.misses) begin
                    if (mismatches < 10)
                        $display("addr %h: exp %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
                                 want.addr, want.hit, want.way, want.hits, want.misses,
                                 o_hit, o_way, o_hit_count, o_miss_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(MODE_LRU);
        test_reset_lookup();
        test_lru_victim();
        test_round_robin();
        test_random_traffic();
        drain_results();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> set_assoc_cache_tag_lookup_core.f
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ctrl.sv
hw/rtl/sacl_dp.sv
hw/rtl/set_assoc_cache_tag_lookup_core.sv
sim/tb.sv
